[hw/rtl/dtrd_pkg.sv]
// Shared types and constants for the request deframer.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package dtrd_pkg;

  localparam logic [31:0] SigWord     = 32'h0050_4144;
  localparam logic [7:0]  TypeRequest = 8'h01;
  localparam logic [15:0] MaxLenReset = 16'd512;

  localparam logic       OpData    = 1'b0;
  localparam logic       OpRestart = 1'b1;

  localparam logic [1:0] KindData  = 2'd0;
  localparam logic [1:0] KindEmpty = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  localparam logic [2:0] HdrLastIdx = 3'd7;
  localparam logic [2:0] HdrLenLo   = 3'd4;
  localparam logic [2:0] HdrLenHi   = 3'd5;
  localparam logic [2:0] HdrType    = 3'd6;

  typedef enum logic [2:0] {
    PhHeader  = 3'b001,
    PhPayload = 3'b010,
    PhError   = 3'b100
  } phase_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic        frame_last;
    logic [15:0] payload_length;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/dap_tcp_request_deframer.sv]
// Request deframer top level: input register, parser, output register.
// Throughput: one byte per cycle while the output register can take a result,
// and bytes without one (header bytes, error phase, restart) never wait;
// the parser state updates once per byte.
// Reset clears the parser to header phase, both stages to empty, and the
// max payload length register to 512.
`default_nettype none

module dap_tcp_request_deframer (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire dtrd_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dtrd_pkg::out_item_t      out_item_o
);

  logic               stage_valid;
  dtrd_pkg::in_item_t stage_item;
  dtrd_pkg::result_t  result;
  logic               out_free;
  logic               advance;

  assign advance = stage_valid && (!result.valid || out_free);

  dtrd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  dtrd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (stage_valid),
    .item_i      (stage_item),
    .step_i      (advance),
    .result_o    (result)
  );

  dtrd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && result.valid),
    .item_i      (result.item),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

[hw/rtl/dtrd_in_stage.sv]
// Input register of the request deframer: holds one accepted beat.
// Depends on dtrd_pkg.
`default_nettype none

module dtrd_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire dtrd_pkg::in_item_t in_item_i,
  input  wire logic              advance_i,
  output logic                   valid_o,
  output dtrd_pkg::in_item_t     item_o
);

  logic               valid_q, valid_d;
  dtrd_pkg::in_item_t item_q;
  logic               load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[hw/rtl/dtrd_parser.sv]
// Header parser and payload counter: judges headers, tags payload beats.
// Depends on dtrd_pkg; holds the max payload length register.
`default_nettype none

module dtrd_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               valid_i,
  input  wire dtrd_pkg::in_item_t item_i,
  input  wire logic               step_i,
  output dtrd_pkg::result_t       result_o
);

  logic [15:0]      max_len_q;
  dtrd_pkg::phase_e phase_q, phase_d;
  logic [2:0]       hdr_idx_q, hdr_idx_d;
  logic             sig_ok_q, sig_ok_d;
  logic             type_ok_q, type_ok_d;
  logic [15:0]      frame_len_q, frame_len_d;
  logic [15:0]      left_q, left_d;
  logic [7:0]       expect_byte;
  logic             last;
  logic             bad;

  assign expect_byte = dtrd_pkg::SigWord[{hdr_idx_q[1:0], 3'b000} +: 8];
  assign last        = (left_q <= 16'd1);
  assign bad         = !sig_ok_q || !type_ok_q || (frame_len_q > max_len_q);

  always_comb begin
    phase_d     = phase_q;
    hdr_idx_d   = hdr_idx_q;
    sig_ok_d    = sig_ok_q;
    type_ok_d   = type_ok_q;
    frame_len_d = frame_len_q;
    left_d      = left_q;
    result_o    = '0;
    result_o.item.payload_length = frame_len_q;
    if (valid_i) begin
      if (item_i.operation == dtrd_pkg::OpRestart) begin
        phase_d     = dtrd_pkg::PhHeader;
        hdr_idx_d   = '0;
        sig_ok_d    = 1'b1;
        type_ok_d   = 1'b0;
        frame_len_d = '0;
        left_d      = '0;
      end else begin
        case (phase_q)
          dtrd_pkg::PhError: begin
          end
          dtrd_pkg::PhPayload: begin
            result_o.valid             = 1'b1;
            result_o.item.result_kind  = dtrd_pkg::KindData;
            result_o.item.payload_byte = item_i.rx_byte;
            result_o.item.frame_last   = last;
            left_d = left_q - 16'd1;
            if (last) begin
              left_d    = '0;
              phase_d   = dtrd_pkg::PhHeader;
              hdr_idx_d = '0;
              sig_ok_d  = 1'b1;
              type_ok_d = 1'b0;
            end
          end
          default: begin
            if (!hdr_idx_q[2]) begin
              if (item_i.rx_byte != expect_byte) begin
                sig_ok_d = 1'b0;
              end
            end else if (hdr_idx_q == dtrd_pkg::HdrLenLo) begin
              frame_len_d = {8'd0, item_i.rx_byte};
            end else if (hdr_idx_q == dtrd_pkg::HdrLenHi) begin
              frame_len_d = {item_i.rx_byte, frame_len_q[7:0]};
            end else if (hdr_idx_q == dtrd_pkg::HdrType) begin
              type_ok_d = (item_i.rx_byte == dtrd_pkg::TypeRequest);
            end
            hdr_idx_d = hdr_idx_q + 3'd1;
            if (hdr_idx_q == dtrd_pkg::HdrLastIdx) begin
              hdr_idx_d = '0;
              if (bad) begin
                phase_d                   = dtrd_pkg::PhError;
                result_o.valid            = 1'b1;
                result_o.item.result_kind = dtrd_pkg::KindError;
              end else if (frame_len_q == 16'd0) begin
                sig_ok_d                  = 1'b1;
                type_ok_d                 = 1'b0;
                result_o.valid            = 1'b1;
                result_o.item.result_kind = dtrd_pkg::KindEmpty;
                result_o.item.frame_last  = 1'b1;
              end else begin
                left_d  = frame_len_q;
                phase_d = dtrd_pkg::PhPayload;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= dtrd_pkg::MaxLenReset;
      phase_q     <= dtrd_pkg::PhHeader;
      hdr_idx_q   <= '0;
      sig_ok_q    <= 1'b1;
      type_ok_q   <= 1'b0;
      frame_len_q <= '0;
      left_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (step_i) begin
        phase_q     <= phase_d;
        hdr_idx_q   <= hdr_idx_d;
        sig_ok_q    <= sig_ok_d;
        type_ok_q   <= type_ok_d;
        frame_len_q <= frame_len_d;
        left_q      <= left_d;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dtrd_out_stage.sv]
// Output register of the request deframer: holds one result beat.
// Depends on dtrd_pkg.
`default_nettype none

module dtrd_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire dtrd_pkg::out_item_t item_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output dtrd_pkg::out_item_t    out_item_o
);

  logic                valid_q, valid_d;
  dtrd_pkg::out_item_t item_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

[sim/deframer_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the request deframer: tracks config writes, predicts result beats from
// accepted input beats and compares each result beat field by field. Depends on dtrd_pkg.
module deframer_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  dtrd_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  dtrd_pkg::out_item_t out_item_i,
  output int                  errors_o,
  output int                  pending_o
);
  import dtrd_pkg::*;

  logic [15:0] max_len;
  phase_e      phase;
  logic [2:0]  hdr_idx;
  logic        sig_ok;
  logic        type_ok;
  logic [15:0] frame_len;
  logic [15:0] bytes_left;
  out_item_t   expected_beats[$];

  function automatic void clear_parser();
    phase      = PhHeader;
    hdr_idx    = '0;
    sig_ok     = 1'b1;
    type_ok    = 1'b0;
    frame_len  = '0;
    bytes_left = '0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] rx, output out_item_t beat);
    logic [7:0] sig_byte;
    beat = '0;
    beat.payload_length = frame_len;
    case (phase)
      PhError: return 1'b0;
      PhPayload: begin
        beat.result_kind  = KindData;
        beat.payload_byte = rx;
        beat.frame_last   = (bytes_left <= 16'd1);
        bytes_left = bytes_left - 16'd1;
        if (beat.frame_last) begin
          bytes_left = '0;
          phase      = PhHeader;
          hdr_idx    = '0;
          sig_ok     = 1'b1;
          type_ok    = 1'b0;
        end
        return 1'b1;
      end
      default: ;
    endcase
    if (hdr_idx < HdrLenLo) begin
      sig_byte = 8'(SigWord >> (8 * hdr_idx));
      if (rx != sig_byte) sig_ok = 1'b0;
    end else if (hdr_idx == HdrLenLo) begin
      frame_len = {8'h00, rx};
    end else if (hdr_idx == HdrLenHi) begin
      frame_len = {rx, frame_len[7:0]};
    end else if (hdr_idx == HdrType) begin
      type_ok = (rx == TypeRequest);
    end
    if (hdr_idx != HdrLastIdx) begin
      hdr_idx = hdr_idx + 3'd1;
      return 1'b0;
    end
    hdr_idx = '0;
    beat.payload_length = frame_len;
    if (!sig_ok || !type_ok || frame_len > max_len) begin
      phase = PhError;
      beat.result_kind = KindError;
      return 1'b1;
    end
    if (frame_len == 16'd0) begin
      sig_ok  = 1'b1;
      type_ok = 1'b0;
      beat.result_kind = KindEmpty;
      beat.frame_last  = 1'b1;
      return 1'b1;
    end
    bytes_left = frame_len;
    phase = PhPayload;
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t beat;
    out_item_t want;
    if (!rst_ni) begin
      max_len = MaxLenReset;
      clear_parser();
      expected_beats.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) max_len = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: kind %0d byte %0h",
                 out_item_i.result_kind, out_item_i.payload_byte);
          errors_o++;
        end else begin
          want = expected_beats.pop_front();
          check_field("result_kind", want.result_kind, out_item_i.result_kind);
          check_field("payload_byte", want.payload_byte, out_item_i.payload_byte);
          check_field("frame_last", want.frame_last, out_item_i.frame_last);
          check_field("payload_length", want.payload_length, out_item_i.payload_length);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.operation == OpRestart) clear_parser();
        else if (deframe_byte(in_item_i.rx_byte, beat)) expected_beats.push_back(beat);
      end
      pending_o = expected_beats.size();
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Top of the request deframer testbench: clock, reset, framed byte stimulus and
// config phases. Depends on dtrd_pkg, the deframer RTL and deframer_checker.
module testbench;
  import dtrd_pkg::*;

  localparam int ItemTarget  = 750;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 6;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  int          errors;
  int          pending;
  int          cycles     = 0;
  int          stall_left = 0;
  int          sent       = 0;
  bit          gaps_on    = 1'b1;
  logic [15:0] cur_max    = MaxLenReset;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  dap_tcp_request_deframer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  deframer_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_item_i  (out_item),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  function automatic bit idle_roll();
    return gaps_on && (((cycles >> 8) & 3) != 3) && ($urandom_range(0, 7) == 0);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (idle_roll()) stall_left <= $urandom_range(1, 7);
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] rx);
    int gap;
    if (idle_roll()) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item.operation <= op;
    in_item.rx_byte   <= rx;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_max_len(input logic [15:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    cur_max = value;
  endtask

  task automatic send_header(input logic [31:0] sig, input logic [15:0] len,
                             input logic [7:0] ftype, input logic [7:0] rsvd, input int nbytes);
    logic [63:0] hdr;
    hdr = {rsvd, ftype, len, sig};
    for (int i = 0; i < nbytes; i++) send_beat(OpData, hdr[8*i +: 8]);
  endtask

  task automatic send_payload(input int n);
    repeat (n) send_beat(OpData, 8'($urandom_range(0, 255)));
  endtask

  task automatic junk_then_restart();
    int n;
    n = $urandom_range(0, 3);
    send_payload(n);
    sent -= n;
    send_beat(OpRestart, 8'($urandom_range(0, 255)));
  endtask

  task automatic random_frame();
    int          pick;
    logic [31:0] sig;
    logic [15:0] len;
    logic [7:0]  ftype;
    logic [7:0]  rsvd;
    pick  = $urandom_range(0, 99);
    sig   = SigWord;
    ftype = TypeRequest;
    rsvd  = 8'($urandom_range(0, 255));
    len   = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(13, 300))
                                         : 16'($urandom_range(0, 12));
    if ($urandom_range(0, 19) == 0 && cur_max <= 16'd300) len = cur_max;
    if (pick < 65) begin
      send_header(sig, len, ftype, rsvd, 8);
      if (len > cur_max) junk_then_restart();
      else send_payload(len);
    end else if (pick < 75 || (pick < 89 && cur_max == 16'hFFFF)) begin
      sig = sig ^ (32'h1 << $urandom_range(0, 31));
      send_header(sig, 16'($urandom_range(0, 65535)), ftype, rsvd, 8);
      junk_then_restart();
    end else if (pick < 83) begin
      ftype = 8'($urandom_range(0, 255));
      if (ftype == TypeRequest) ftype = ~TypeRequest;
      send_header(sig, len, ftype, rsvd, 8);
      junk_then_restart();
    end else if (pick < 89) begin
      len = 16'($urandom_range(int'(cur_max) + 1, 65535));
      send_header(sig, len, ftype, rsvd, 8);
      junk_then_restart();
    end else if (pick < 95) begin
      send_header(sig, len, ftype, rsvd, $urandom_range(0, 7));
      send_beat(OpRestart, 8'($urandom_range(0, 255)));
    end else begin
      len = 16'($urandom_range(2, 12));
      send_header(sig, len, ftype, rsvd, 8);
      if (len <= cur_max) send_payload($urandom_range(1, int'(len) - 1));
      junk_then_restart();
    end
  endtask

  task automatic random_frames(input int n);
    int goal;
    goal = sent + n;
    while (sent < goal) random_frame();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_header(SigWord, 16'd2, TypeRequest, 8'hFF, 8);
    send_beat(OpData, 8'h00);
    send_beat(OpData, 8'hFF);
    send_header(SigWord, 16'd0, TypeRequest, 8'h00, 8);
    send_header(SigWord, 16'd1, 8'hFE, 8'h5A, 8);
    send_beat(OpData, 8'hFF);
    send_beat(OpRestart, 8'h00);

    settle();
    random_frames(ItemTarget * 2 / 10);
    set_max_len(16'd0);
    random_frames(ItemTarget / 10);
    set_max_len(16'hFFFF);
    random_frames(ItemTarget * 2 / 10);
    set_max_len(16'd5);
    random_frames(ItemTarget * 2 / 10);
    set_max_len(MaxLenReset);
    gaps_on = 1'b0;
    random_frames(ItemTarget * 2 / 10);

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/dtrd_pkg.sv
hw/rtl/dtrd_in_stage.sv
hw/rtl/dtrd_parser.sv
hw/rtl/dtrd_out_stage.sv
hw/rtl/dap_tcp_request_deframer.sv
sim/deframer_checker.sv
sim/testbench.sv
